// ===== rtl/bpfc_pkg.sv =====
`timescale 1ns / 1ps

package bpfc_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int IDX_W       = 12;
  localparam int LEN_W       = 13;
  localparam int GAIN_W      = 16;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int MUL_W       = 25;
  localparam int DIGIT_W     = 24;
  localparam int ROUND_SHIFT = 38;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'b1;

  localparam logic [LEN_W-1:0]  IR_LENGTH_RST = 13'd1;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd32768;

  localparam logic signed [SAMPLE_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] NEG_MIN = 24'sh800000;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           coeff_index;
    logic signed [SAMPLE_W-1:0] coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       block_last;
  } out_item_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
    logic horner;
  } mac_ctrl_t;

endpackage

// ===== rtl/bpfc_mac.sv =====
`timescale 1ns / 1ps

module bpfc_mac import bpfc_pkg::*; #(
  parameter int ACC_W = 89
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [MUL_W-1:0] a_in,
  input  logic signed [MUL_W-1:0] b_in,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] prod_r;
  logic                      en_d_r;
  logic                      horner_d_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_d_r     <= 1'b0;
      horner_d_r <= 1'b0;
    end else begin
      en_d_r     <= ctrl.en;
      horner_d_r <= ctrl.horner;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod_r <= a_in * b_in;
    end
    acc_r <= acc_nxt;
  end

  // horner mode shifts the partial result up one digit before adding
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (en_d_r) begin
      if (horner_d_r) begin
        acc_nxt = (acc_r <<< DIGIT_W) + ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/bpfc_blkbuf.sv =====
`timescale 1ns / 1ps

module bpfc_blkbuf import bpfc_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic signed [SAMPLE_W-1:0]       wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic signed [SAMPLE_W-1:0]       rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/block_partitioned_fir_convolver.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// in_       in   in_valid/in_stall   in_data  (operation, sample, coeff_index, coeff_value)
// out_      out  out_valid/out_stall out_data (out_sample, block_last)
// cfg_      in   cfg_we              cfg_index, cfg_wdata
//
// a push reads ir_length taps, tap count capped at MAX_TAPS:
// one tap per cycle through the shared multiplier, then the gain digit by digit on it
// a push that fills a block then drains the block buffer, each result read and then loaded out
// coefficient write and unused codes finish in the accept cycle, a clear then runs the sweep
// after reset a sweep over all MAX_TAPS addresses zeroes both stores; after a clear, only the history
// in_stall is high whenever an item or the sweep is in progress; out_stall only holds the drain

module block_partitioned_fir_convolver import bpfc_pkg::*; #(
  parameter int BLOCK_SIZE = 64,
  parameter int MAX_TAPS   = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int BW     = $clog2(BLOCK_SIZE);
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int SUM_W  = 2 * SAMPLE_W + AW;
  localparam int ND     = (SUM_W - 1 + DIGIT_W - 1) / DIGIT_W;
  localparam int DW     = (ND > 1) ? $clog2(ND) : 1;
  localparam int MAG_W  = ND * DIGIT_W;
  localparam int ACC_W  = MAG_W + GAIN_W + 1;
  localparam int Q_W    = ACC_W - ROUND_SHIFT;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(MAX_TAPS - 1);
  localparam logic [BW-1:0]    LAST_SLOT  = BW'(BLOCK_SIZE - 1);
  localparam logic [DW-1:0]    LAST_DIGIT = DW'(ND - 1);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MAC,
    S_MWAIT,
    S_ABS,
    S_HORN,
    S_HWAIT,
    S_RND,
    S_DRAIN_RD,
    S_DRAIN_LD
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic                       clr_coef_r, clr_coef_nxt;
  logic [AW-1:0]              hp_r, hp_nxt;
  logic [AW-1:0]              rpos_r, rpos_nxt;
  logic [AW-1:0]              k_r, k_nxt;
  logic                       rd_v_r, rd_v_nxt;
  logic                       dly_r, dly_nxt;
  logic [DW-1:0]              dcnt_r, dcnt_nxt;
  logic [BW-1:0]              fill_r, fill_nxt;
  logic [BW-1:0]              didx_r, didx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;
  logic                       neg_r, neg_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic [LEN_W-1:0]           ir_length_r;
  logic [GAIN_W-1:0]          gain_r;

  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_q_r;
  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic                       coef_we, hist_we, tap_re;
  logic [AW-1:0]              coef_wa, hist_wa;
  logic signed [SAMPLE_W-1:0] coef_wd, hist_wd;

  logic                       in_accept;
  logic [TW-1:0]              taps;
  mac_ctrl_t                  mac_ctrl;
  logic signed [MUL_W-1:0]    mac_a, mac_b;
  logic signed [ACC_W-1:0]    mac_acc;
  logic [SUM_W-1:0]           sum_abs;
  logic [ACC_W-1:0]           rnd_sum;
  logic [Q_W-1:0]             q_val;
  logic signed [SAMPLE_W-1:0] res_val;
  logic                       buf_we, buf_re;
  logic signed [SAMPLE_W-1:0] buf_rd;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (32'(ir_length_r) > MAX_TAPS) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(ir_length_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_length_r <= IR_LENGTH_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IR_LENGTH: ir_length_r <= cfg_wdata[LEN_W-1:0];
        CFG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // tap and history stores
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (tap_re) begin
      coef_q_r <= coef_mem[k_r];
      hist_q_r <= hist_mem[rpos_r];
    end
  end

  assign mac_a = (state_r == S_HORN) ? $signed({1'b0, mag_r[MAG_W-1 -: DIGIT_W]})
                                     : MUL_W'(coef_q_r);
  assign mac_b = (state_r == S_HORN) ? $signed({{(MUL_W - GAIN_W){1'b0}}, gain_r})
                                     : MUL_W'(hist_q_r);

  bpfc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a_in  (mac_a),
    .b_in  (mac_b),
    .acc   (mac_acc)
  );

  bpfc_blkbuf #(
    .DEPTH (BLOCK_SIZE)
  ) u_blkbuf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (fill_r),
    .wr_data (res_val),
    .rd_en   (buf_re),
    .rd_addr (didx_r),
    .rd_data (buf_rd)
  );

  // magnitude of the tap sum, and rounding of magnitude * gain back to Q1.23
  always_comb begin
    sum_abs = mac_acc[SUM_W-1] ? (SUM_W'(0) - mac_acc[SUM_W-1:0]) : mac_acc[SUM_W-1:0];
    rnd_sum = ACC_W'(mac_acc) + ROUND_BIAS;
    q_val   = rnd_sum[ACC_W-1:ROUND_SHIFT];
    if (|q_val[Q_W-1:SAMPLE_W-1]) begin
      res_val = neg_r ? NEG_MIN : POS_MAX;
    end else if (neg_r) begin
      res_val = SAMPLE_W'(0) - $signed({1'b0, q_val[SAMPLE_W-2:0]});
    end else begin
      res_val = $signed({1'b0, q_val[SAMPLE_W-2:0]});
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_coef_nxt  = clr_coef_r;
    hp_nxt        = hp_r;
    rpos_nxt      = rpos_r;
    k_nxt         = k_r;
    rd_v_nxt      = (state_r == S_MAC);
    dly_nxt       = dly_r;
    dcnt_nxt      = dcnt_r;
    fill_nxt      = fill_r;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    coef_we       = 1'b0;
    coef_wa       = clr_addr_r;
    coef_wd       = '0;
    hist_we       = 1'b0;
    hist_wa       = clr_addr_r;
    hist_wd       = '0;
    tap_re        = 1'b0;
    buf_we        = 1'b0;
    buf_re        = 1'b0;
    mac_ctrl.clr    = 1'b0;
    mac_ctrl.en     = rd_v_r || (state_r == S_HORN);
    mac_ctrl.horner = (state_r == S_HORN);

    case (state_r)
      S_CLR: begin
        hist_we = 1'b1;
        coef_we = clr_coef_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_data.operation)
            OP_PUSH: begin
              hist_we      = 1'b1;
              hist_wa      = hp_r;
              hist_wd      = in_data.sample;
              mac_ctrl.clr = 1'b1;
              rpos_nxt     = hp_r;
              hp_nxt       = (hp_r == LAST_ADDR) ? '0 : hp_r + 1'b1;
              k_nxt        = '0;
              if (taps == '0) begin
                dly_nxt   = 1'b1;
                state_nxt = S_MWAIT;
              end else begin
                state_nxt = S_MAC;
              end
            end
            OP_COEF: begin
              if (32'(in_data.coeff_index) < MAX_TAPS) begin
                coef_we = 1'b1;
                coef_wa = AW'(in_data.coeff_index);
                coef_wd = in_data.coeff_value;
              end
            end
            OP_CLEAR: begin
              clr_coef_nxt = 1'b0;
              clr_addr_nxt = '0;
              hp_nxt       = '0;
              fill_nxt     = '0;
              state_nxt    = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        tap_re   = 1'b1;
        k_nxt    = k_r + 1'b1;
        rpos_nxt = (rpos_r == '0) ? LAST_ADDR : rpos_r - 1'b1;
        if (32'(k_r) + 32'd1 == 32'(taps)) begin
          dly_nxt   = 1'b1;
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        // wait for the last product to land in the accumulator
        if (dly_r == 1'b0) begin
          state_nxt = S_ABS;
        end else begin
          dly_nxt = 1'b0;
        end
      end
      S_ABS: begin
        neg_nxt      = mac_acc[SUM_W-1];
        mag_nxt      = MAG_W'(sum_abs);
        mac_ctrl.clr = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_HORN;
      end
      S_HORN: begin
        // most significant digit first
        mag_nxt  = mag_r << DIGIT_W;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == LAST_DIGIT) begin
          state_nxt = S_HWAIT;
        end
      end
      S_HWAIT: begin
        state_nxt = S_RND;
      end
      S_RND: begin
        buf_we = 1'b1;
        if (fill_r == LAST_SLOT) begin
          fill_nxt  = '0;
          didx_nxt  = '0;
          state_nxt = S_DRAIN_RD;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        buf_re    = 1'b1;
        state_nxt = S_DRAIN_LD;
      end
      S_DRAIN_LD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_sample = buf_rd;
          out_data_nxt.block_last = (didx_r == LAST_SLOT);
          if (didx_r == LAST_SLOT) begin
            state_nxt = S_IDLE;
          end else begin
            didx_nxt  = didx_r + 1'b1;
            state_nxt = S_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_coef_r  <= 1'b1;
      hp_r        <= '0;
      rpos_r      <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      dly_r       <= 1'b0;
      dcnt_r      <= '0;
      fill_r      <= '0;
      didx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_coef_r  <= clr_coef_nxt;
      hp_r        <= hp_nxt;
      rpos_r      <= rpos_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= rd_v_nxt;
      dly_r       <= dly_nxt;
      dcnt_r      <= dcnt_nxt;
      fill_r      <= fill_nxt;
      didx_r      <= didx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
  end

  // a result only appears out of the drain sequence
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DRAIN_LD))
    else $error("result loaded outside the drain");

  // a held result blocks the next buffer entry
  a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN_LD && out_valid_r && out_stall) |=> (state_r == S_DRAIN_LD))
    else $error("drain moved on while output was stalled");

  // the tap loop never runs with zero taps
  a_mac_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (taps != '0))
    else $error("tap loop entered with no taps");

  // scaling always finishes its digits before rounding
  a_horner_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HWAIT) |-> $past(state_r == S_HORN && dcnt_r == LAST_DIGIT))
    else $error("scaling cut short");

  // no push starts while the clearing sweep is running
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_addr_r != LAST_ADDR) |=> (state_r == S_CLR))
    else $error("clearing sweep left early");

endmodule
